>>> rtl/dcmec_pkg.sv
// Shared types and constants for the dual-channel sample conditioner.
`timescale 1ns / 1ps
package dcmec_pkg;

  localparam int unsigned SampleW  = 12;
  localparam int unsigned Window   = 5;
  localparam int unsigned FracBits = 8;
  localparam int unsigned EmaW     = SampleW + FracBits;
  localparam int unsigned AlphaW   = 9;
  localparam int unsigned SlotW    = $clog2(Window);
  localparam int unsigned FillW    = $clog2(Window + 1);

  localparam logic [2:0] RegThr  = 3'd0;
  localparam logic [2:0] RegHyst = 3'd1;
  localparam logic [2:0] RegDb   = 3'd2;
  localparam logic [2:0] RegRole = 3'd3;
  localparam logic [2:0] RegAlph = 3'd4;

  typedef struct packed {
    logic        channel;
    logic [11:0] sample;
  } in_word_t;

  typedef struct packed {
    logic        source;
    logic [11:0] filtered;
    logic [6:0]  percent;
    logic        pot_apply;
    logic        pot_target;
    logic        night;
    logic        night_edge;
  } out_word_t;

  // Serial multiplier request and reply.
  typedef struct packed {
    logic                         start;
    logic [EmaW:0]                mcand;
    logic [AlphaW-1:0]            mplier;
  } mul_req_t;

  typedef struct packed {
    logic                         done;
    logic [EmaW+AlphaW:0]         prod;
  } mul_rsp_t;

endpackage

>>> rtl/dual_channel_median_ema_conditioner.sv
// Top level: median of five, EMA, day/night hysteresis and pot percent.
// From an accepted word to its result: ranking of median candidates one at a time against
// each filled entry, a serial multiply once seeded, a percent search and a finish step.
// Only one word is in flight: a new word is taken only when the previous result has left.
// Reset (synchronous, rst_n low): control and state cleared, registers to defaults.
`timescale 1ns / 1ps
module dual_channel_median_ema_conditioner (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  dcmec_pkg::in_word_t   in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output dcmec_pkg::out_word_t  out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [2:0]            cfg_index,
  input  logic [11:0]           cfg_data
);
  localparam int unsigned EW = dcmec_pkg::EmaW;
  localparam int unsigned FB = dcmec_pkg::FracBits;
  localparam int unsigned SW = dcmec_pkg::SampleW;
  localparam int unsigned PW = EW + dcmec_pkg::AlphaW + 1;
  localparam int unsigned WIN = dcmec_pkg::Window;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_RANK  = 7'b0000010,
    S_PICK  = 7'b0000100,
    S_MUL   = 7'b0001000,
    S_PCT   = 7'b0010000,
    S_FIN   = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  logic [11:0] thr_r;
  logic [10:0] hyst_r;
  logic [6:0]  db_r;
  logic        role_r;
  logic [8:0]  alpha_r;

  logic [SW-1:0] ring_r [2*WIN];
  logic [dcmec_pkg::SlotW-1:0] slot_r [2];
  logic [dcmec_pkg::FillW-1:0] fill_r [2];
  logic [EW-1:0] ema_r [2];
  logic [1:0]    seeded_r;
  logic [6:0]    applied_r;
  logic          pseed_r, night_r, nseed_r;

  logic          ch_r;
  logic [dcmec_pkg::SlotW-1:0] ci_r;   // candidate under test
  logic [dcmec_pkg::SlotW-1:0] ji_r;   // entry compared against it
  logic [dcmec_pkg::FillW-1:0] less_r, leq_r;
  logic [SW-1:0] med_r;
  logic          neg_r;
  logic [EW-1:0] ema_new_r;
  logic [SW-1:0] filt_r;
  logic [6:0]    pct_r;
  logic [2:0]    pbit_r;
  dcmec_pkg::out_word_t obuf_r;

  dcmec_pkg::mul_req_t mreq;
  dcmec_pkg::mul_rsp_t mrsp;

  dcmec_sermul u_mul (.clk(clk), .rst_n(rst_n), .req(mreq), .rsp(mrsp));

  logic idle;
  assign idle      = (state_r == S_IDLE);
  assign in_ready  = idle;
  assign cfg_ready = 1'b1;
  assign out_valid = (state_r == S_OUT);
  assign out_data  = obuf_r;

  logic [dcmec_pkg::FillW-1:0] n_c;
  logic [dcmec_pkg::FillW-1:0] half_c;
  logic [3:0]    base_c;
  logic [SW-1:0] cand_c, other_c;
  assign n_c    = fill_r[ch_r];
  assign half_c = n_c >> 1;
  assign base_c = ch_r ? 4'(WIN) : 4'd0;
  assign cand_c  = ring_r[base_c + 4'(ci_r)];
  assign other_c = ring_r[base_c + 4'(ji_r)];

  // The candidate is the median whenever it is picked, so it feeds the average directly.
  logic [EW-1:0] e_c;
  logic [EW:0]   medx_c;
  assign e_c    = ema_r[ch_r];
  assign medx_c = {1'b0, cand_c, {FB{1'b0}}};

  // Step and clamp after the product arrives.
  logic [PW-1:0]     step_c;
  logic signed [EW+2:0] sum_c;
  logic [EW-1:0]     clamp_c;
  localparam logic [EW-1:0] Top = {12'hFFF, {FB{1'b0}}};
  always_comb begin
    if (neg_r) begin
      step_c = (mrsp.prod + PW'(255)) >> 8;
      sum_c  = $signed({3'b0, e_c}) - $signed({1'b0, step_c[EW+1:0]});
    end else begin
      step_c = mrsp.prod >> 8;
      sum_c  = $signed({3'b0, e_c}) + $signed({1'b0, step_c[EW+1:0]});
    end
    if (sum_c < 0) clamp_c = '0;
    else if (sum_c > $signed({3'b0, Top})) clamp_c = Top;
    else clamp_c = sum_c[EW-1:0];
  end

  logic [SW-1:0] round_c;
  assign round_c = SW'((ema_new_r + EW'(1 << (FB - 1))) >> FB);

  // Percent found one bit per cycle: largest p with p*4095 <= filt*100.
  logic [6:0]  ptry_c;
  logic [19:0] lhs_c, rhs_c;
  assign ptry_c = pct_r | (7'd1 << pbit_r);
  assign lhs_c  = 20'(ptry_c) * 20'd4095;
  assign rhs_c  = 20'(filt_r) * 20'd100;

  // Day/night and deadband decisions.
  logic        night_n, edge_n, apply_n;
  logic [6:0]  diff_c;
  logic signed [13:0] lo_c;
  logic [12:0] hi_c;
  always_comb begin
    night_n = night_r;
    edge_n  = 1'b0;
    apply_n = 1'b0;
    lo_c = $signed({2'b0, thr_r}) - $signed({3'b0, hyst_r});
    hi_c = {1'b0, thr_r} + {2'b0, hyst_r};
    diff_c = (pct_r >= applied_r) ? pct_r - applied_r : applied_r - pct_r;
    if (!ch_r) begin
      if (!nseed_r) begin
        night_n = (filt_r < thr_r);
      end else if (!night_r && ($signed({2'b0, filt_r}) < lo_c)) begin
        night_n = 1'b1;
        edge_n  = 1'b1;
      end else if (night_r && ({1'b0, filt_r} > hi_c)) begin
        night_n = 1'b0;
        edge_n  = 1'b1;
      end
    end else begin
      apply_n = !pseed_r || (diff_c >= db_r);
    end
  end

  always_comb begin
    state_nxt = state_r;
    mreq = '0;
    case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_RANK;
      S_RANK: begin
        // Median is the entry whose rank window covers fill/2.
        if (ji_r == dcmec_pkg::SlotW'(n_c - 1)) begin
          state_nxt = S_PICK;
        end
      end
      S_PICK: begin
        if (less_r <= half_c && half_c < leq_r) begin
          state_nxt = seeded_r[ch_r] ? S_MUL : S_PCT;
          mreq.start = seeded_r[ch_r];
        end else begin
          state_nxt = S_RANK;
        end
        mreq.mcand  = (medx_c >= {1'b0, e_c}) ? medx_c - {1'b0, e_c}
                                               : {1'b0, e_c} - medx_c;
        mreq.mplier = alpha_r;
      end
      S_MUL: if (mrsp.done) state_nxt = S_PCT;
      S_PCT: if (pbit_r == 3'd0) state_nxt = S_FIN;
      S_FIN: state_nxt = S_OUT;
      S_OUT: if (out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      thr_r    <= 12'd2048;
      hyst_r   <= 11'd205;
      db_r     <= 7'd2;
      role_r   <= 1'b0;
      alpha_r  <= 9'd77;
      slot_r[0] <= '0; slot_r[1] <= '0;
      fill_r[0] <= '0; fill_r[1] <= '0;
      ema_r[0]  <= '0; ema_r[1]  <= '0;
      seeded_r <= '0;
      applied_r <= '0;
      pseed_r  <= 1'b0;
      night_r  <= 1'b0;
      nseed_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          dcmec_pkg::RegThr:  thr_r   <= cfg_data[11:0];
          dcmec_pkg::RegHyst: hyst_r  <= cfg_data[10:0];
          dcmec_pkg::RegDb:   db_r    <= cfg_data[6:0];
          dcmec_pkg::RegRole: role_r  <= cfg_data[0];
          dcmec_pkg::RegAlph: alpha_r <= cfg_data[8:0];
          default: ;
        endcase
      end
      case (state_r)
        S_IDLE: if (in_valid) begin
          slot_r[in_data.channel] <= (slot_r[in_data.channel] == dcmec_pkg::SlotW'(WIN - 1))
                                     ? '0 : slot_r[in_data.channel] + 1'b1;
          if (fill_r[in_data.channel] != dcmec_pkg::FillW'(WIN))
            fill_r[in_data.channel] <= fill_r[in_data.channel] + 1'b1;
        end
        S_PICK: if (less_r <= half_c && half_c < leq_r && !seeded_r[ch_r]) begin
          ema_r[ch_r]    <= medx_c[EW-1:0];
          seeded_r[ch_r] <= 1'b1;
        end
        S_MUL: if (mrsp.done) ema_r[ch_r] <= clamp_c;
        S_FIN: begin
          if (!ch_r) begin
            night_r <= night_n;
            nseed_r <= 1'b1;
          end else if (apply_n) begin
            applied_r <= pct_r;
            pseed_r   <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        ch_r   <= in_data.channel;
        ci_r   <= '0;
        ji_r   <= '0;
        less_r <= '0;
        leq_r  <= '0;
        if (in_valid)
          ring_r[(in_data.channel ? 4'(WIN) : 4'd0) + 4'(slot_r[in_data.channel])]
            <= in_data.sample;
      end
      S_RANK: begin
        less_r <= less_r + dcmec_pkg::FillW'(other_c < cand_c);
        leq_r  <= leq_r + dcmec_pkg::FillW'(other_c <= cand_c);
        ji_r   <= ji_r + 1'b1;
      end
      S_PICK: begin
        med_r  <= cand_c;
        neg_r  <= medx_c < {1'b0, e_c};
        ema_new_r <= medx_c[EW-1:0];
        ci_r   <= ci_r + 1'b1;
        ji_r   <= '0;
        less_r <= '0;
        leq_r  <= '0;
        pct_r  <= '0;
        pbit_r <= 3'd6;
        filt_r <= cand_c;
      end
      S_MUL: if (mrsp.done) begin
        ema_new_r <= clamp_c;
        filt_r    <= SW'((clamp_c + EW'(1 << (FB - 1))) >> FB);
      end
      S_PCT: begin
        if (lhs_c <= rhs_c) pct_r <= ptry_c;
        pbit_r <= pbit_r - 3'd1;
      end
      S_FIN: begin
        obuf_r.source     <= ch_r;
        obuf_r.filtered   <= round_c;
        obuf_r.percent    <= ch_r ? pct_r : 7'd0;
        obuf_r.pot_apply  <= ch_r & apply_n;
        obuf_r.pot_target <= ch_r & role_r;
        obuf_r.night      <= night_n;
        obuf_r.night_edge <= edge_n;
      end
      default: ;
    endcase
  end

  // The filtered value after a seed is the median itself.
  a_seed_filt: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PICK && state_nxt == S_PCT) |=> (filt_r == med_r))
    else $error("seed path filtered value mismatch");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(obuf_r)))
    else $error("result word changed while stalled");
  a_no_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_ready)
    else $error("input accepted while busy");
  a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.percent <= 7'd100))
    else $error("percent out of range");
endmodule

>>> rtl/dcmec_sermul.sv
// Shift-and-add multiplier taking one multiplier bit per cycle.
`timescale 1ns / 1ps
module dcmec_sermul (
  input  logic                clk,
  input  logic                rst_n,
  input  dcmec_pkg::mul_req_t req,
  output dcmec_pkg::mul_rsp_t rsp
);
  localparam int unsigned PW = dcmec_pkg::EmaW + dcmec_pkg::AlphaW + 1;

  logic [PW-1:0]                  acc_r, acc_nxt;
  logic [PW-1:0]                  mc_r, mc_nxt;
  logic [dcmec_pkg::AlphaW-1:0]   mp_r, mp_nxt;
  logic [3:0]                     cnt_r, cnt_nxt;
  logic                           busy_r, busy_nxt;
  logic                           done_r, done_nxt;

  always_comb begin
    acc_nxt  = acc_r;
    mc_nxt   = mc_r;
    mp_nxt   = mp_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      acc_nxt  = '0;
      mc_nxt   = {{(PW-dcmec_pkg::EmaW-1){1'b0}}, req.mcand};
      mp_nxt   = req.mplier;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (mp_r[0]) begin
        acc_nxt = acc_r + mc_r;
      end
      mc_nxt  = mc_r << 1;
      mp_nxt  = mp_r >> 1;
      cnt_nxt = cnt_r + 4'd1;
      if (cnt_r == 4'(dcmec_pkg::AlphaW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    mc_r  <= mc_nxt;
    mp_r  <= mp_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign rsp.done = done_r;
  assign rsp.prod = acc_r;
endmodule
